### src/stdp_pkg.sv
// shared types, constants and index tables for the symmetric tensor dyad product unit
package stdp_pkg;

    localparam int NUM_ENTRIES = 21;
    localparam int IDX_W       = 5;
    localparam int IN_FIELD_W  = 32;
    localparam int NUM_COMP    = 6;
    localparam int VAL_W       = 64;
    localparam int SUM_W       = 66;
    localparam int IN_DATA_W   = 2 * NUM_COMP * IN_FIELD_W;
    localparam int OUT_DATA_W  = 72;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

    localparam logic [CFG_IDX_W-1:0] REG_PRODUCT_KIND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OPERAND_FORM = 1'b1;

    // packed index -> matrix row / column slot
    localparam logic [2:0] ENTRY_ROW [NUM_ENTRIES] = '{
        3'd0,
        3'd0, 3'd1,
        3'd0, 3'd1, 3'd2,
        3'd0, 3'd1, 3'd2, 3'd3,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5
    };
    localparam logic [2:0] ENTRY_COL [NUM_ENTRIES] = '{
        3'd0,
        3'd1, 3'd1,
        3'd2, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd3, 3'd3,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
    };

    // slot order xx, yy, zz, xy, xz, yz
    localparam logic [1:0] SLOT_I [NUM_COMP] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1};
    localparam logic [1:0] SLOT_J [NUM_COMP] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             swapped;
        logic [1:0]       halvings;
    } t_issue;

    // tensor index pair -> component position (fields xx, yy, zz, xy, yz, xz)
    function automatic logic [2:0] comp_pos(input logic [1:0] i, input logic [1:0] j);
        logic [3:0] key;
        logic [2:0] pos;
        key = {i, j};
        case (key)
            4'b0000: pos = 3'd0;
            4'b0101: pos = 3'd1;
            4'b1010: pos = 3'd2;
            4'b0001, 4'b0100: pos = 3'd3;
            4'b0110, 4'b1001: pos = 3'd4;
            4'b0010, 4'b1000: pos = 3'd5;
            default: pos = 3'd0;
        endcase
        return pos;
    endfunction

endpackage

### src/stdp_datapath.sv
// four-stage entry pipeline: operand select, multiply, sum and halve, saturate
module stdp_datapath import stdp_pkg::*; #(
    parameter int COMPONENT_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_issue                            i_issue,
    input  logic signed [COMPONENT_WIDTH-1:0] i_a [NUM_COMP],
    input  logic signed [COMPONENT_WIDTH-1:0] i_b [NUM_COMP],
    input  logic                              i_ready,
    output logic                              o_adv,
    output logic                              o_valid,
    output logic [IDX_W-1:0]                  o_idx,
    output logic                              o_last,
    output logic [VAL_W-1:0]                  o_value
);

    localparam int PROD_W = 2 * COMPONENT_WIDTH;

    t_issue r_s1, r_s2, r_s3, r_s4;
    logic signed [COMPONENT_WIDTH-1:0] r_x [4];
    logic signed [COMPONENT_WIDTH-1:0] r_y [4];
    logic signed [COMPONENT_WIDTH-1:0] n_x [4];
    logic signed [COMPONENT_WIDTH-1:0] n_y [4];
    logic signed [PROD_W-1:0]          r_p [4];
    logic signed [SUM_W-1:0]           r_sum;
    logic signed [SUM_W-1:0]           n_sum;
    logic [VAL_W-1:0]                  r_val;
    logic [VAL_W-1:0]                  n_val;
    logic [2:0] row, col;
    logic [1:0] si, sj, sk, sl;

    assign o_adv = !r_s4.valid || i_ready;

    // stage 1 operand selection
    always_comb begin
        row = ENTRY_ROW[i_issue.idx];
        col = ENTRY_COL[i_issue.idx];
        si  = SLOT_I[row];
        sj  = SLOT_J[row];
        sk  = SLOT_I[col];
        sl  = SLOT_J[col];
        if (i_issue.swapped) begin
            n_x[0] = i_a[comp_pos(si, sk)];
            n_y[0] = i_b[comp_pos(sj, sl)];
            n_x[1] = i_a[comp_pos(si, sl)];
            n_y[1] = i_b[comp_pos(sj, sk)];
            n_x[2] = i_b[comp_pos(si, sk)];
            n_y[2] = i_a[comp_pos(sj, sl)];
            n_x[3] = i_b[comp_pos(si, sl)];
            n_y[3] = i_a[comp_pos(sj, sk)];
        end else begin
            n_x[0] = i_a[comp_pos(si, sj)];
            n_y[0] = i_b[comp_pos(sk, sl)];
            n_x[1] = i_b[comp_pos(si, sj)];
            n_y[1] = i_a[comp_pos(sk, sl)];
            n_x[2] = '0;
            n_y[2] = '0;
            n_x[3] = '0;
            n_y[3] = '0;
        end
    end

    // stage 3 sum of four sign-extended products, then floor halving
    always_comb begin
        n_sum = SUM_W'(r_p[0]) + SUM_W'(r_p[1]) + SUM_W'(r_p[2]) + SUM_W'(r_p[3]);
        n_sum = n_sum >>> r_s2.halvings;
    end

    // stage 4 saturation to 64 bits
    always_comb begin
        if (r_sum[SUM_W-1:VAL_W-1] == '0 || r_sum[SUM_W-1:VAL_W-1] == '1) begin
            n_val = r_sum[VAL_W-1:0];
        end else if (r_sum[SUM_W-1]) begin
            n_val = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            n_val = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
        end else if (o_adv) begin
            r_s1 <= i_issue;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            r_s4 <= r_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            for (int n = 0; n < 4; n++) begin
                r_x[n] <= n_x[n];
                r_y[n] <= n_y[n];
                r_p[n] <= r_x[n] * r_y[n];
            end
            r_sum <= n_sum;
            r_val <= n_val;
        end
    end

    assign o_valid = r_s4.valid;
    assign o_idx   = r_s4.idx;
    assign o_last  = r_s4.last;
    assign o_value = r_val;

endmodule

### src/sym_tensor_dyad_product_unit.sv
// top level: config registers, entry sequencer and stream ports of the dyad product unit
//
//  channel   dir  handshake                  payload
//  s stream  in   i_s_tvalid / o_s_tready    i_s_tdata: a_xx..a_xz, b_xx..b_xz, 32 bits each
//  m stream  out  o_m_tvalid / i_m_tready    o_m_tdata: entry_index, entry_value; o_m_tlast
//  config    in   i_cfg_we                   i_cfg_idx, i_cfg_data
//
// one request gives 21 entries, one per cycle while the m side does not stall;
// the next request is taken as the last entry of the current one issues. each
// entry passes the operand, product, sum and saturation registers in turn.
// synchronous active-low reset clears config, sequencer and pipeline valids.
// a stall on the m side freezes the whole pipeline; nothing is lost or repeated.
module sym_tensor_dyad_product_unit import stdp_pkg::*; #(
    parameter int COMPONENT_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [IN_DATA_W-1:0]    i_s_tdata,   // a_xx a_yy a_zz a_xy a_yz a_xz b_xx b_yy b_zz b_xy b_yz b_xz
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [OUT_DATA_W-1:0]   o_m_tdata,   // entry_index[4:0], entry_value[68:5], zero pad
    output logic                    o_m_tlast,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    logic r_product_kind, r_operand_form;
    logic r_busy;
    logic [IDX_W-1:0] r_cnt;
    logic signed [COMPONENT_WIDTH-1:0] r_a [NUM_COMP];
    logic signed [COMPONENT_WIDTH-1:0] r_b [NUM_COMP];
    logic adv, take, issue_last;
    t_issue issue;
    logic dp_valid, dp_last;
    logic [IDX_W-1:0] dp_idx;
    logic [VAL_W-1:0] dp_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_product_kind <= 1'b0;
            r_operand_form <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PRODUCT_KIND: r_product_kind <= i_cfg_data[0];
                REG_OPERAND_FORM: r_operand_form <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign issue_last = r_busy && adv && (r_cnt == LAST_IDX);
    assign o_s_tready = !r_busy || issue_last;
    assign take       = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (take) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (issue_last) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy && adv) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // single form keeps a copy of a in place of b
    always_ff @(posedge i_clk) begin
        if (take) begin
            for (int n = 0; n < NUM_COMP; n++) begin
                r_a[n] <= i_s_tdata[n*IN_FIELD_W +: COMPONENT_WIDTH];
                r_b[n] <= r_operand_form ?
                          i_s_tdata[(n+NUM_COMP)*IN_FIELD_W +: COMPONENT_WIDTH] :
                          i_s_tdata[n*IN_FIELD_W +: COMPONENT_WIDTH];
            end
        end
    end

    always_comb begin
        issue.valid    = r_busy;
        issue.idx      = r_cnt;
        issue.last     = (r_cnt == LAST_IDX);
        issue.swapped  = r_product_kind;
        issue.halvings = {1'b0, r_product_kind} + {1'b0, !r_operand_form};
    end

    stdp_datapath #(
        .COMPONENT_WIDTH(COMPONENT_WIDTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (issue),
        .i_a     (r_a),
        .i_b     (r_b),
        .i_ready (i_m_tready),
        .o_adv   (adv),
        .o_valid (dp_valid),
        .o_idx   (dp_idx),
        .o_last  (dp_last),
        .o_value (dp_value)
    );

    assign o_m_tvalid = dp_valid;
    assign o_m_tlast  = dp_last;
    assign o_m_tdata  = {{(OUT_DATA_W-VAL_W-IDX_W){1'b0}}, dp_value, dp_idx};

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[IDX_W-1:0] == LAST_IDX))
        else $error("last flag on an entry other than the final one");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= LAST_IDX))
        else $error("entry counter out of range");

    a_take_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (!r_busy || r_cnt == LAST_IDX))
        else $error("request taken while entries remain");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && adv && r_cnt != LAST_IDX) |=>
        (r_busy && r_cnt == $past(r_cnt) + 1'b1))
        else $error("entry counter skipped or repeated");

endmodule

### test/tb_sym_tensor_dyad_product_unit.sv
// self-checking testbench for the symmetric tensor dyad product unit
`timescale 1ns / 1ps

module tb_sym_tensor_dyad_product_unit;
    import stdp_pkg::*;

    localparam int  COMP_W      = 32;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  MAX_SHOWN   = 40;
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_entry;

    // predicts the 21 packed entries of each request and matches them against the m stream
    class dyad_scoreboard;
        t_entry entry_q[$];
        int     errors;
        int     shown;
        bit     swapped;
        bit     pair;

        task report(input string msg);
            errors++;
            if (shown < MAX_SHOWN) begin
                $display("mismatch: %s", msg);
                shown++;
            end
        endtask

        // tensor index pair -> field position (xx, yy, zz, xy, yz, xz)
        function int field_pos(input int i, input int j);
            if (i == j) return i;
            if (i + j == 1) return 3;
            if (i + j == 3) return 4;
            return 5;
        endfunction

        function longint component(input logic [IN_DATA_W-1:0] d, input int grp,
                                   input int i, input int j);
            logic [63:0] raw;
            raw = 64'(d[(grp * NUM_COMP + field_pos(i, j)) * IN_FIELD_W +: IN_FIELD_W]);
            return longint'(raw << (64 - COMP_W)) >>> (64 - COMP_W);
        endfunction

        // matrix slot order xx, yy, zz, xy, xz, yz
        function void slot_pair(input int s, output int i, output int j);
            case (s)
                3: begin i = 0; j = 1; end
                4: begin i = 0; j = 2; end
                5: begin i = 1; j = 2; end
                default: begin i = s; j = s; end
            endcase
        endfunction

        function void note_request(input logic [IN_DATA_W-1:0] d);
            longint ta [3][3];
            longint tb [3][3];
            logic signed [71:0] acc;
            int p, q, u, v, k, shifts;
            t_entry e;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    ta[i][j] = component(d, 0, i, j);
                    tb[i][j] = pair ? component(d, 1, i, j) : ta[i][j];
                end
            end
            shifts = (swapped ? 1 : 0) + (pair ? 0 : 1);
            k = 0;
            for (int c = 0; c < 6; c++) begin
                for (int r = 0; r <= c; r++) begin
                    slot_pair(r, p, q);
                    slot_pair(c, u, v);
                    acc = '0;
                    if (swapped) begin
                        acc = acc + ta[p][u] * tb[q][v];
                        acc = acc + ta[p][v] * tb[q][u];
                        acc = acc + tb[p][u] * ta[q][v];
                        acc = acc + tb[p][v] * ta[q][u];
                    end else begin
                        acc = acc + ta[p][q] * tb[u][v];
                        acc = acc + tb[p][q] * ta[u][v];
                    end
                    for (int h = 0; h < shifts; h++) acc = acc >>> 1;
                    e.idx  = IDX_W'(k);
                    e.last = (k == NUM_ENTRIES - 1);
                    if (acc[71:63] == {9{acc[63]}})
                        e.value = acc[63:0];
                    else if (acc[71])
                        e.value = 64'h8000_0000_0000_0000;
                    else
                        e.value = 64'h7FFF_FFFF_FFFF_FFFF;
                    entry_q.push_back(e);
                    k++;
                end
            end
        endfunction

        task check_entry(input logic [OUT_DATA_W-1:0] d, input logic tl);
            t_entry e;
            if (entry_q.size() == 0) begin
                report($sformatf("entry %0d with no request pending", d[IDX_W-1:0]));
            end else begin
                e = entry_q.pop_front();
                if (d[IDX_W-1:0] !== e.idx)
                    report($sformatf("index got %0d want %0d", d[IDX_W-1:0], e.idx));
                if (d[IDX_W +: VAL_W] !== e.value)
                    report($sformatf("entry %0d value got %h want %h",
                                     e.idx, d[IDX_W +: VAL_W], e.value));
                if (tl !== e.last)
                    report($sformatf("entry %0d tlast got %b want %b", e.idx, tl, e.last));
            end
        endtask
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tlast;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    dyad_scoreboard sb;
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int cycle_count   = 0;

    sym_tensor_dyad_product_unit #(.COMPONENT_WIDTH(COMP_W)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_sym_tensor_dyad_product_unit: FAIL");
            $finish;
        end
    end

    // m side: check every accepted entry, then pick tready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_entry(o_m_tdata, o_m_tlast);
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task send_request(input logic [IN_DATA_W-1:0] d);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(d);
    endtask

    task wait_drain();
        while (sb.entry_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task set_config(input bit kind, input bit form);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_PRODUCT_KIND;
        i_cfg_data <= kind;
        @(posedge i_clk);
        i_cfg_idx  <= REG_OPERAND_FORM;
        i_cfg_data <= form;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.swapped = kind;
        sb.pair    = form;
    endtask

    function logic [31:0] pick_extreme();
        case ($urandom_range(5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0001_0000;
            default: return 32'h0000_0001;
        endcase
    endfunction

    function logic [IN_DATA_W-1:0] random_request();
        logic [IN_DATA_W-1:0] d;
        int mode;
        mode = $urandom_range(9);
        for (int f = 0; f < 2 * NUM_COMP; f++) begin
            if (mode < 6)
                d[f * IN_FIELD_W +: IN_FIELD_W] = $urandom;
            else if (mode < 8)
                d[f * IN_FIELD_W +: IN_FIELD_W] = pick_extreme();
            else
                d[f * IN_FIELD_W +: IN_FIELD_W] = 32'($signed(18'($urandom)));
        end
        return d;
    endfunction

    // zeros, all max, all min, max against min, alternating signs, all random
    function logic [IN_DATA_W-1:0] directed_request(input int n);
        logic [IN_DATA_W-1:0] d;
        for (int f = 0; f < 2 * NUM_COMP; f++) begin
            case (n)
                0: d[f * IN_FIELD_W +: IN_FIELD_W] = 32'h0;
                1: d[f * IN_FIELD_W +: IN_FIELD_W] = Q_MAX;
                2: d[f * IN_FIELD_W +: IN_FIELD_W] = Q_MIN;
                3: d[f * IN_FIELD_W +: IN_FIELD_W] = (f < NUM_COMP) ? Q_MAX : Q_MIN;
                4: d[f * IN_FIELD_W +: IN_FIELD_W] = ((f % 2) == (f / NUM_COMP)) ? Q_MIN : Q_MAX;
                default: d[f * IN_FIELD_W +: IN_FIELD_W] = $urandom;
            endcase
        end
        return d;
    endfunction

    initial begin
        bit kinds [5];
        bit forms [5];
        int stall_src [4];
        int stall_snk [4];
        kinds = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        forms = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
        stall_src = '{0, 56, 0, 36};
        stall_snk = '{0, 0, 56, 36};
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // first group runs on the reset values of the registers
        for (int g = 0; g < 5; g++) begin
            if (g > 0) begin
                wait_drain();
                set_config(kinds[g], forms[g]);
            end
            src_idle_pct   = 0;
            sink_stall_pct = 0;
            if (g < 4) begin
                for (int n = 0; n < 6; n++) send_request(directed_request(n));
            end
            for (int ph = 0; ph < 4; ph++) begin
                src_idle_pct   = stall_src[ph];
                sink_stall_pct = stall_snk[ph];
                repeat (25) send_request(random_request());
            end
            i_s_tvalid <= 1'b0;
        end
        sink_stall_pct = 0;
        wait_drain();
        if (sb.errors == 0 && sb.entry_q.size() == 0) begin
            $display("tb_sym_tensor_dyad_product_unit: PASS");
        end else begin
            $display("tb_sym_tensor_dyad_product_unit: FAIL");
        end
        $finish;
    end

endmodule

### files.f
src/stdp_pkg.sv
src/stdp_datapath.sv
src/sym_tensor_dyad_product_unit.sv
test/tb_sym_tensor_dyad_product_unit.sv
